// ===== rtl/rbb_pkg.sv =====
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types, register codes and constant dividers for the 3x3 box blur
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

    // one rgb pixel, channel 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_rgb;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_ENABLE  = 2'd2;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    // reciprocal constants: exact for sums below 32768 and 2048
    localparam logic [12:0] DIV9_MUL = 13'd7282;
    localparam logic [9:0]  DIV3_MUL = 10'd683;

    // sum of nine 8 bit values divided by 9
    function automatic logic [7:0] div9(input logic [11:0] s);
        logic [24:0] p;
        p = 25'(s) * 25'(DIV9_MUL);
        return p[23:16];
    endfunction

    // sum of three 8 bit values divided by 3
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'(DIV3_MUL);
        return p[18:11];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rbb_line_buffer.sv =====
// ----------------------------------------------------------------------------
// rbb_line_buffer
// two row memories (two rows up, one row up) with one write and one
// registered read port each
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_line_buffer
    import rbb_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_rgb               o_rd_upper,
    output t_rgb               o_rd_middle,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_rgb          i_wr_upper,
    input  wire t_rgb          i_wr_middle
);

    t_rgb r_mem_upper  [DEPTH];
    t_rgb r_mem_middle [DEPTH];
    t_rgb r_rd_upper;
    t_rgb r_rd_middle;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr] <= i_wr_upper;
        end
        if (i_rd_en) begin
            r_rd_upper <= r_mem_upper[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_middle[i_wr_addr] <= i_wr_middle;
        end
        if (i_rd_en) begin
            r_rd_middle <= r_mem_middle[i_rd_addr];
        end
    end

    assign o_rd_upper  = r_rd_upper;
    assign o_rd_middle = r_rd_middle;

endmodule

`default_nettype wire

// ===== rtl/rgb_box_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// 3x3 mean filter on a raster rgb pixel stream with optional grey output
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while no stall holds the stream
// and gives, for every pixel whose full 3x3 neighbourhood lies in the frame,
// the truncated mean of the nine pixels per channel, so a frame of W x H
// gives (W-2) x (H-2) results; the first two rows and columns give none.
// With grey mode set all three outputs carry the truncated mean of the
// blurred r, g and b. frame_last marks the last result of a frame. The line
// buffer read lands with the pixel in the input register, then come the
// nine-term sum, the divide by nine, and grey and the output register; the
// stream runs at one pixel per clock when not stalled, limited by the single
// read and write port of each line buffer memory. The two line buffers are
// MAX_WIDTH x 24 bit memories with no clearing pass after reset: they are
// filled by the first two rows of every frame. Width is clamped to
// 3..MAX_WIDTH and height to at least 3; configuration must be written only
// while the stream is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_box_blur_3x3
    import rbb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel requests in
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    // result requests out
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out,
    output logic                       o_frame_last
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [10:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic        r_gray_enable;

    // position counters
    logic [AW-1:0] r_col;
    logic [11:0]   r_row;
    logic [AW-1:0] n_col;
    logic [11:0]   n_row;

    // stage a: accepted pixel and line buffer read data
    logic          r_a_valid;
    logic          r_a_prod;
    logic          r_a_last;
    logic [AW-1:0] r_a_col;
    t_rgb          r_a_bot;
    t_rgb          a_top;
    t_rgb          a_mid;

    // window of the two previous columns: 0..2 older, 3..5 newer (top, mid, bot)
    t_rgb r_win [6];

    // stage b: channel sums
    logic             r_b_valid;
    logic             r_b_last;
    logic [2:0][11:0] r_b_sum;
    logic [2:0][11:0] n_sum;

    // stage c: blurred channels
    logic       r_c_valid;
    logic       r_c_last;
    t_rgb       r_c_blur;

    // stage d: output register
    logic       r_d_valid;
    logic       r_d_last;
    t_rgb       r_d_pix;
    t_rgb       n_d_pix;
    logic [9:0] gray_sum;

    // handshake
    logic a_ready;
    logic a_adv;
    logic b_ready;
    logic c_ready;
    logic d_ready;
    logic in_acc;

    // frame geometry
    logic [12:0] width_eff;
    logic [11:0] height_eff;
    logic        col_end;
    logic        row_end;
    logic        prod;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_gray_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[11:0];
                CFG_GRAY_ENABLE:  r_gray_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage moves on when the next one has room;
    // border pixels leave stage a without a slot in stage b
    // ------------------------------------------------------------------
    assign d_ready    = !r_d_valid || !i_out_stall;
    assign c_ready    = !r_c_valid || d_ready;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_adv      = r_a_valid && (!r_a_prod || b_ready);
    assign a_ready    = !r_a_valid || a_adv;
    assign in_acc     = i_in_valid && a_ready;
    assign o_in_stall = !a_ready;

    // ------------------------------------------------------------------
    // geometry and counters, evaluated for the pixel being taken
    // ------------------------------------------------------------------
    always_comb begin
        if (13'(r_frame_width) < 13'd3) begin
            width_eff = 13'd3;
        end else if (13'(r_frame_width) > 13'(MAX_WIDTH)) begin
            width_eff = 13'(MAX_WIDTH);
        end else begin
            width_eff = 13'(r_frame_width);
        end
        height_eff = (r_frame_height < 12'd3) ? 12'd3 : r_frame_height;

        col_end = 13'(r_col) >= (width_eff - 13'd1);
        row_end = r_row >= (height_eff - 12'd1);
        prod    = (r_row >= 12'd2) && (r_col >= AW'(2));

        if (col_end) begin
            n_col = '0;
            n_row = row_end ? 12'd0 : r_row + 12'd1;
        end else begin
            n_col = r_col + AW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // stage a: read both line buffers at the current column; the pixel's
    // write-back happens as it leaves, well before the same column comes
    // round again
    // ------------------------------------------------------------------
    rbb_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buffer (
        .i_clk       (i_clk),
        .i_rd_en     (in_acc),
        .i_rd_addr   (r_col),
        .o_rd_upper  (a_top),
        .o_rd_middle (a_mid),
        .i_wr_en     (a_adv),
        .i_wr_addr   (r_a_col),
        .i_wr_upper  (a_mid),
        .i_wr_middle (r_a_bot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_bot  <= {i_blue_in, i_green_in, i_red_in};
            r_a_col  <= r_col;
            r_a_prod <= prod;
            r_a_last <= col_end && row_end;
        end
    end

    // window shifts by one column for every pixel, border ones included
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= a_top;
            r_win[4] <= a_mid;
            r_win[5] <= r_a_bot;
        end
    end

    // ------------------------------------------------------------------
    // stage b: nine-term sum per channel
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = 12'(a_top[c]) + 12'(a_mid[c]) + 12'(r_a_bot[c])
                     + 12'(r_win[0][c]) + 12'(r_win[1][c]) + 12'(r_win[2][c])
                     + 12'(r_win[3][c]) + 12'(r_win[4][c]) + 12'(r_win[5][c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_adv && r_a_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b_sum  <= n_sum;
            r_b_last <= r_a_last;
        end
    end

    // ------------------------------------------------------------------
    // stage c: divide by nine
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready) begin
            r_c_blur[0] <= div9(r_b_sum[0]);
            r_c_blur[1] <= div9(r_b_sum[1]);
            r_c_blur[2] <= div9(r_b_sum[2]);
            r_c_last    <= r_b_last;
        end
    end

    // ------------------------------------------------------------------
    // stage d: optional grey level, then the output register
    // ------------------------------------------------------------------
    always_comb begin
        gray_sum = 10'(r_c_blur[0]) + 10'(r_c_blur[1]) + 10'(r_c_blur[2]);
        if (r_gray_enable) begin
            n_d_pix[0] = div3(gray_sum);
            n_d_pix[1] = n_d_pix[0];
            n_d_pix[2] = n_d_pix[0];
        end else begin
            n_d_pix = r_c_blur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready) begin
            r_d_pix  <= n_d_pix;
            r_d_last <= r_c_last;
        end
    end

    assign o_out_valid  = r_d_valid;
    assign o_red_out    = r_d_pix[0];
    assign o_green_out  = r_d_pix[1];
    assign o_blue_out   = r_d_pix[2];
    assign o_frame_last = r_d_last;

endmodule

`default_nettype wire
